// ----- sv/hlca_pkg.sv -----
// Shared types and constants for the header list chunk allocator.
`timescale 1ns / 1ps
package hlca_pkg;

    localparam logic [15:0] FREE_MARK   = 16'h8000;
    localparam logic [14:0] OFFSET_MASK = 15'h7FFF;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOSPACE   = 2'd1;
    localparam logic [1:0] ST_NOTFOUND  = 2'd2;

    localparam logic [2:0] REG_BUFFER_WORDS = 3'd0;

    typedef struct packed {
        logic        cmd;
        logic [14:0] size_words;
        logic [14:0] chunk_offset;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [14:0] result_offset;
    } t_res;

endpackage

// ----- sv/hlca_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read.
`timescale 1ns / 1ps
module hlca_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/header_list_chunk_allocator.sv -----
// Top level: header list chunk allocator with table RAM and command sequencer.
//
// Usage: pulse start with i_req while busy is low; the command is taken at that
// edge and busy rises unless it is rejected in idle. When done, o_done is high
// for one cycle with o_result, and busy falls in the same cycle, so a new
// command may follow at once. Results cannot be held off by the receiver;
// they are valid only while o_done. Allocate scans the list until a free
// entry fits, else appends at the end; a split inserts a new entry there and
// shifts the later entries up. Free scans for the entry, compacts the list
// after a merge, or drops trailing free entries when it freed the last one.
// The single read port of the header table RAM sets the pace: the scan reads
// one entry per cycle, and a list shift moves each entry by a read then a write state.
// Reset empties the list (entry count zero) and sets buffer_words to 4096;
// RAM needs no clearing pass since entries beyond the count are never read. The
// user must write buffer_words over the APB port at byte address 0 only while idle; the block does not enforce it.
`timescale 1ns / 1ps
module header_list_chunk_allocator
    import hlca_pkg::*;
#(
    parameter int MAX_ENTRIES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_req        i_req,
    output logic        o_done,
    output t_res        o_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_ASCAN, S_ALAST, S_AEND, S_INSR, S_INSW,
        S_FSCAN, S_FNEXT, S_FTAIL, S_FTRD, S_RMR, S_RMW
    } t_state;

    t_state       r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [14:0]  r_bw;
    logic [14:0]  r_size, n_size;
    logic [14:0]  r_off, n_off;
    logic [AW-1:0] r_i, n_i;
    logic [15:0]  r_prev, n_prev;
    logic [CW-1:0] r_j, n_j;
    logic [AW-1:0] r_pos, n_pos;
    logic [14:0]  r_val, n_val;
    logic [1:0]   r_k, n_k;
    logic         r_done, n_done;
    t_res         r_res, n_res;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [15:0]   wdata, rdata;

    logic [CW-1:0]      i_nx;
    logic signed [16:0] avail;
    logic [CW:0]        rm_sum;
    logic               pf, nf;

    hlca_ram #(.WIDTH(16), .DEPTH(MAX_ENTRIES)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    function automatic logic signed [23:0] room_of(
        input logic [14:0] bw, input logic [CW-1:0] n, input logic [14:0] last);
        logic signed [23:0] r;
        r = $signed({7'd0, bw, 2'b00}) - $signed(24'((32'(n) + 32'd2) * 32'd2))
            - $signed({7'd0, last, 2'b00});
        return r;
    endfunction

    assign i_nx   = CW'(r_i) + CW'(1);
    assign avail  = $signed({2'b00, rdata[14:0]}) - $signed({2'b00, r_prev[14:0]});
    assign rm_sum = {1'b0, r_j} + (CW + 1)'(r_k);
    assign pf     = (r_i != '0) && r_prev[15];
    assign nf     = rdata[15];

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_size  = r_size;
        n_off   = r_off;
        n_i     = r_i;
        n_prev  = r_prev;
        n_j     = r_j;
        n_pos   = r_pos;
        n_val   = r_val;
        n_k     = r_k;
        n_done  = 1'b0;
        n_res   = r_res;
        we      = 1'b0;
        waddr   = r_i;
        wdata   = rdata;
        raddr   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_size = i_req.size_words;
                    n_off  = i_req.chunk_offset;
                    n_i    = '0;
                    n_prev = '0;
                    if (i_req.cmd == CMD_ALLOC) begin
                        if (i_req.size_words == '0 || r_bw == '0) begin
                            n_done = 1'b1;
                            n_res  = '{status: ST_NOSPACE, result_offset: '0};
                        end else if (r_cnt == '0) begin
                            n_state = S_AEND;
                        end else begin
                            n_state = S_ASCAN;
                        end
                    end else begin
                        if (i_req.chunk_offset == '0 || r_cnt == '0) begin
                            n_done = 1'b1;
                            n_res  = '{status: ST_NOTFOUND, result_offset: '0};
                        end else begin
                            n_state = S_FSCAN;
                        end
                    end
                end
            end
            S_ASCAN: begin
                if (rdata[15] && avail == $signed({2'b00, r_size})) begin
                    we      = 1'b1;
                    waddr   = r_i;
                    wdata   = {1'b0, rdata[14:0]};
                    n_done  = 1'b1;
                    n_res   = '{status: ST_OK, result_offset: rdata[14:0]};
                    n_state = S_IDLE;
                end else if (rdata[15] && avail > $signed({2'b00, r_size})) begin
                    if (r_cnt >= CW'(MAX_ENTRIES)) begin
                        n_done  = 1'b1;
                        n_res   = '{status: ST_NOSPACE, result_offset: '0};
                        n_state = S_IDLE;
                    end else begin
                        raddr   = AW'(r_cnt - CW'(1));
                        n_pos   = r_i;
                        n_val   = r_prev[14:0] + r_size;
                        n_state = S_ALAST;
                    end
                end else begin
                    n_prev = rdata;
                    if (i_nx == r_cnt) begin
                        n_state = S_AEND;
                    end else begin
                        raddr = AW'(i_nx);
                        n_i   = AW'(i_nx);
                    end
                end
            end
            S_ALAST: begin
                if (room_of(r_bw, r_cnt, rdata[14:0]) > 24'sd0) begin
                    n_j     = r_cnt;
                    n_state = S_INSR;
                end else begin
                    n_done  = 1'b1;
                    n_res   = '{status: ST_NOSPACE, result_offset: '0};
                    n_state = S_IDLE;
                end
            end
            S_AEND: begin
                n_state = S_IDLE;
                n_done  = 1'b1;
                if (r_cnt < CW'(MAX_ENTRIES) && room_of(r_bw, r_cnt, r_prev[14:0])
                        >= $signed({7'd0, r_size, 2'b00})) begin
                    we    = 1'b1;
                    waddr = AW'(r_cnt);
                    wdata = {1'b0, r_prev[14:0] + r_size};
                    n_cnt = r_cnt + CW'(1);
                    n_res = '{status: ST_OK, result_offset: r_prev[14:0] + r_size};
                end else begin
                    n_res = '{status: ST_NOSPACE, result_offset: '0};
                end
            end
            S_INSR: begin
                if (r_j == CW'(r_pos)) begin
                    we      = 1'b1;
                    waddr   = r_pos;
                    wdata   = {1'b0, r_val};
                    n_cnt   = r_cnt + CW'(1);
                    n_done  = 1'b1;
                    n_res   = '{status: ST_OK, result_offset: r_val};
                    n_state = S_IDLE;
                end else begin
                    raddr   = AW'(r_j - CW'(1));
                    n_state = S_INSW;
                end
            end
            S_INSW: begin
                we      = 1'b1;
                waddr   = AW'(r_j);
                wdata   = rdata;
                n_j     = r_j - CW'(1);
                n_state = S_INSR;
            end
            S_FSCAN: begin
                if (rdata == {1'b0, r_off}) begin
                    if (i_nx == r_cnt) begin
                        n_j     = CW'(r_i);
                        n_state = S_FTAIL;
                    end else begin
                        we      = 1'b1;
                        waddr   = r_i;
                        wdata   = rdata | FREE_MARK;
                        raddr   = AW'(i_nx);
                        n_state = S_FNEXT;
                    end
                end else begin
                    n_prev = rdata;
                    if (i_nx == r_cnt) begin
                        n_done  = 1'b1;
                        n_res   = '{status: ST_NOTFOUND, result_offset: '0};
                        n_state = S_IDLE;
                    end else begin
                        raddr = AW'(i_nx);
                        n_i   = AW'(i_nx);
                    end
                end
            end
            S_FNEXT: begin
                if (!pf && !nf) begin
                    n_done  = 1'b1;
                    n_res   = '{status: ST_OK, result_offset: '0};
                    n_state = S_IDLE;
                end else begin
                    n_j     = CW'(r_i) - CW'(pf);
                    n_k     = 2'(pf) + 2'(nf);
                    n_state = S_RMR;
                end
            end
            S_RMR: begin
                if (rm_sum >= (CW + 1)'(r_cnt)) begin
                    n_cnt   = r_cnt - CW'(r_k);
                    n_done  = 1'b1;
                    n_res   = '{status: ST_OK, result_offset: '0};
                    n_state = S_IDLE;
                end else begin
                    raddr   = AW'(rm_sum);
                    n_state = S_RMW;
                end
            end
            S_RMW: begin
                we      = 1'b1;
                waddr   = AW'(r_j);
                wdata   = rdata;
                n_j     = r_j + CW'(1);
                n_state = S_RMR;
            end
            S_FTAIL: begin
                if (r_j != '0 && r_prev[15]) begin
                    if (r_j == CW'(1)) begin
                        n_cnt   = '0;
                        n_done  = 1'b1;
                        n_res   = '{status: ST_OK, result_offset: '0};
                        n_state = S_IDLE;
                    end else begin
                        raddr   = AW'(r_j - CW'(2));
                        n_j     = r_j - CW'(1);
                        n_state = S_FTRD;
                    end
                end else begin
                    n_cnt   = r_j;
                    n_done  = 1'b1;
                    n_res   = '{status: ST_OK, result_offset: '0};
                    n_state = S_IDLE;
                end
            end
            S_FTRD: begin
                n_prev  = rdata;
                n_state = S_FTAIL;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_bw    <= 15'd4096;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_done  <= n_done;
            if (psel && penable && pwrite && paddr[2] == REG_BUFFER_WORDS[2]) begin
                r_bw <= pwdata[14:0];
            end
        end
        r_size <= n_size;
        r_off  <= n_off;
        r_i    <= n_i;
        r_prev <= n_prev;
        r_j    <= n_j;
        r_pos  <= n_pos;
        r_val  <= n_val;
        r_k    <= n_k;
        r_res  <= n_res;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_res;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_BUFFER_WORDS[2]) ? {17'd0, r_bw} : 32'd0;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_ENTRIES))
        else $error("entry count above table depth");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(busy) || $past(start)))
        else $error("result without a command");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status != ST_OK) |-> (o_result.result_offset == '0))
        else $error("failed result carries an offset");

    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req.cmd == CMD_ALLOC && i_req.size_words != '0
            && r_bw != '0) |=> busy)
        else $error("allocate did not start");

endmodule

// ----- dv/tb_header_list_chunk_allocator.sv -----
// Testbench for the header list chunk allocator: directed and random commands.
`timescale 1ns / 1ps
module tb_header_list_chunk_allocator;
    import hlca_pkg::*;

    localparam int MAXE = 64;
    localparam int SETTLE = 250;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_req        i_req = '0;
    logic        o_done;
    t_res        o_result;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    header_list_chunk_allocator #(.MAX_ENTRIES(MAXE)) DUT (.*);

    always #2 i_clk = ~i_clk;

    logic [15:0] mdl_table [MAXE];
    int          mdl_count;
    int          mdl_buf_words;
    t_res        pending_results [$];
    int          errors = 0;
    bit          quiet = 1'b0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d want %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic mdl_insert(input int pos, input logic [15:0] v);
        for (int j = mdl_count; j > pos; j--) mdl_table[j] = mdl_table[j-1];
        mdl_table[pos] = v;
        mdl_count++;
    endtask

    task automatic mdl_remove(input int pos, input int k);
        for (int j = pos; j + k < mdl_count; j++) mdl_table[j] = mdl_table[j+k];
        for (int j = mdl_count - k; j < mdl_count; j++) mdl_table[j] = '0;
        mdl_count -= k;
    endtask

    task automatic mdl_alloc(input int size, output logic [1:0] st, output int off);
        int     n;
        int     prev;
        int     avail;
        int     last;
        longint room;
        n = mdl_count;
        off = 0;
        st = ST_NOSPACE;
        if (size == 0 || mdl_buf_words == 0) return;
        for (int i = 0; i < n; i++) begin
            if (mdl_table[i][15]) begin
                prev = (i > 0) ? int'(mdl_table[i-1][14:0]) : 0;
                avail = int'(mdl_table[i][14:0]) - prev;
                if (avail == size) begin
                    mdl_table[i][15] = 1'b0;
                    off = mdl_table[i][14:0];
                    st = ST_OK;
                    return;
                end
                if (avail > size) begin
                    if (n >= MAXE) return;
                    last = mdl_table[n-1][14:0];
                    room = 4 * longint'(mdl_buf_words) - 2 * (longint'(n) + 2)
                           - 4 * longint'(last);
                    if (room <= 0) return;
                    off = (prev + size) & 32'h7FFF;
                    mdl_insert(i, {1'b0, 15'(off)});
                    st = ST_OK;
                    return;
                end
            end
        end
        if (n >= MAXE) return;
        last = (n > 0) ? int'(mdl_table[n-1][14:0]) : 0;
        room = 4 * longint'(mdl_buf_words) - 2 * (longint'(n) + 2)
               - 4 * longint'(last);
        if (room >= 4 * longint'(size)) begin
            off = (size + last) & 32'h7FFF;
            mdl_table[n] = {1'b0, 15'(off)};
            mdl_count = n + 1;
            st = ST_OK;
        end
    endtask

    task automatic mdl_free(input int off, output logic [1:0] st);
        int i;
        int c;
        int idx;
        int shift;
        st = ST_NOTFOUND;
        if (off == 0) return;
        for (i = 0; i < mdl_count; i++)
            if (mdl_table[i] == 16'(off)) break;
        if (i >= mdl_count) return;
        st = ST_OK;
        if (i + 1 == mdl_count) begin
            c = i;
            mdl_table[i] = '0;
            while (c > 0 && mdl_table[c-1][15]) begin
                mdl_table[c-1] = '0;
                c--;
            end
            mdl_count = c;
        end else begin
            idx = i;
            shift = 0;
            mdl_table[i][15] = 1'b1;
            if (i > 0 && mdl_table[i-1][15]) begin
                shift++;
                idx--;
            end
            if (mdl_table[i+1][15]) shift++;
            if (shift > 0) mdl_remove(idx, shift);
        end
    endtask

    task automatic predict_result(input t_req r, output t_res res);
        logic [1:0]  st;
        int          off;
        off = 0;
        if (r.cmd == CMD_ALLOC) mdl_alloc(r.size_words, st, off);
        else mdl_free(r.chunk_offset, st);
        if (st != ST_OK) off = 0;
        res.status = st;
        res.result_offset = 15'(off);
    endtask

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", o_result.status, -1);
            end else begin
                want = pending_results.pop_front();
                if (o_result.status !== want.status)
                    report_mismatch("status", o_result.status, want.status);
                if (o_result.result_offset !== want.result_offset)
                    report_mismatch("result_offset", o_result.result_offset,
                                    want.result_offset);
            end
        end
    end

    task automatic send_cmd(input t_req r);
        t_res want;
        @(negedge i_clk);
        if (!quiet && $urandom_range(99) < 28) begin
            start = 1'b0;
            repeat ($urandom_range(4, 1)) @(negedge i_clk);
        end
        start = 1'b1;
        i_req = r;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        predict_result(r, want);
        pending_results.push_back(want);
    endtask

    task automatic send_alloc(input int size);
        t_req r;
        r.cmd = CMD_ALLOC;
        r.size_words = 15'(size);
        r.chunk_offset = 15'($urandom);
        send_cmd(r);
    endtask

    task automatic send_free(input int off);
        t_req r;
        r.cmd = CMD_FREE;
        r.size_words = 15'($urandom);
        r.chunk_offset = 15'(off);
        send_cmd(r);
    endtask

    task automatic drain;
        @(negedge i_clk);
        start = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_buffer_words(input int words);
        drain();
        @(negedge i_clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = 3'(REG_BUFFER_WORDS) << 2;
        pwdata = 32'(words);
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        mdl_buf_words = words & 32'h7FFF;
    endtask

    task automatic free_all;
        while (mdl_count > 0) send_free(mdl_table[mdl_count-1][14:0]);
    endtask

    task automatic test_basic_cases;
        send_free(0);
        send_alloc(0);
        send_alloc(32767);
        send_alloc(1);
        send_alloc(10);
        send_alloc(20);
        send_alloc(5);
        send_free(12345);
        send_free(31);
        send_free(31);
        send_free(11);
        send_free(1);
        send_alloc(20);
        send_alloc(3);
        send_free(36);
        send_free(3);
        free_all();
    endtask

    task automatic test_zero_buffer;
        set_buffer_words(0);
        send_alloc(1);
        send_alloc(32767);
        set_buffer_words(32767);
        send_alloc(32767);
        send_alloc(1);
        free_all();
    endtask

    task automatic test_table_full;
        set_buffer_words(32767);
        quiet = 1'b1;
        for (int k = 0; k < MAXE; k++) send_alloc(2);
        send_alloc(1);
        send_free(20);
        send_free(24);
        send_alloc(2);
        send_alloc(1);
        send_free(22);
        send_alloc(4);
        quiet = 1'b0;
        free_all();
    endtask

    task automatic run_random(input int items, input int words);
        set_buffer_words(words);
        for (int k = 0; k < items; k++) begin
            if ($urandom_range(99) < 55) begin
                if ($urandom_range(99) < 8) send_alloc($urandom);
                else send_alloc($urandom_range(words > 8 ? words / 8 : 4, 1));
            end else if (mdl_count > 0 && $urandom_range(99) < 80) begin
                send_free(mdl_table[$urandom_range(mdl_count - 1)][14:0]);
            end else begin
                send_free($urandom);
            end
        end
    endtask

    task automatic test_random;
        run_random(140, 4096);
        run_random(125, 48);
        quiet = 1'b1;
        run_random(125, 32767);
        quiet = 1'b0;
        run_random(125, 300);
        run_random(125, 16);
    endtask

    initial begin
        for (int j = 0; j < MAXE; j++) mdl_table[j] = '0;
        mdl_count = 0;
        mdl_buf_words = 4096;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_basic_cases();
        test_zero_buffer();
        test_table_full();
        test_random();
        drain();
        if (errors == 0) $display("header_list_chunk_allocator verification clean");
        else $display("header_list_chunk_allocator verification failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("header_list_chunk_allocator verification failed");
        $finish;
    end

endmodule
